// ----- hw/rtl/i2cms_pkg.sv -----
package i2cms_pkg;

    localparam int BUFFER_DEPTH = 256;
    localparam int BUF_AW       = $clog2(BUFFER_DEPTH);
    localparam int CNT_W        = 9;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(BUFFER_DEPTH);

    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_EVENT = 2'd2;
    localparam logic [1:0] ACT_READ  = 2'd3;

    localparam logic [1:0] ACK_LEAVE = 2'd0;
    localparam logic [1:0] ACK_SET   = 2'd1;
    localparam logic [1:0] ACK_CLEAR = 2'd2;

    localparam logic [1:0] RES_NORMAL    = 2'd0;
    localparam logic [1:0] RES_ARB_LOST  = 2'd1;
    localparam logic [1:0] RES_BUS_ERROR = 2'd2;

    localparam logic [7:0] ST_MASK         = 8'hF8;
    localparam logic [7:0] ST_BUS_ERROR    = 8'h00;
    localparam logic [7:0] ST_START        = 8'h08;
    localparam logic [7:0] ST_RSTART       = 8'h10;
    localparam logic [7:0] ST_MT_SLA_ACK   = 8'h18;
    localparam logic [7:0] ST_MT_SLA_NACK  = 8'h20;
    localparam logic [7:0] ST_MT_DATA_ACK  = 8'h28;
    localparam logic [7:0] ST_MT_DATA_NACK = 8'h30;
    localparam logic [7:0] ST_ARB_LOST     = 8'h38;
    localparam logic [7:0] ST_MR_SLA_ACK   = 8'h40;
    localparam logic [7:0] ST_MR_SLA_NACK  = 8'h48;
    localparam logic [7:0] ST_MR_DATA_ACK  = 8'h50;
    localparam logic [7:0] ST_MR_DATA_NACK = 8'h58;
    localparam logic [7:0] ST_IDLE         = 8'hF8;

    typedef struct packed {
        logic             set_start;
        logic             load_valid;
        logic [7:0]       load_byte;
        logic             use_send;
        logic             use_recv;
        logic [1:0]       ack_mode;
        logic             send_stop;
        logic             clear_start;
        logic             clear_interrupt;
        logic             finished;
        logic [1:0]       outcome;
        logic [CNT_W-1:0] received_count;
    } cmd_t;

    typedef struct packed {
        logic             set_start;
        logic             load_valid;
        logic [7:0]       load_byte;
        logic [1:0]       ack_mode;
        logic             send_stop;
        logic             clear_start;
        logic             clear_interrupt;
        logic             finished;
        logic [1:0]       outcome;
        logic [CNT_W-1:0] received_count;
        logic [7:0]       read_byte;
    } result_t;

    typedef struct packed {
        logic              send_we;
        logic [BUF_AW-1:0] send_waddr;
        logic [7:0]        send_wdata;
        logic              send_re;
        logic [BUF_AW-1:0] send_raddr;
        logic              recv_we;
        logic [BUF_AW-1:0] recv_waddr;
        logic [7:0]        recv_wdata;
        logic              recv_re;
        logic [BUF_AW-1:0] recv_raddr;
    } mem_req_t;

endpackage

// ----- hw/rtl/i2cms_store.sv -----
module i2cms_store (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [i2cms_pkg::BUF_AW-1:0] wr_addr,
    input  logic [7:0]                 wr_data,
    input  logic                       rd_en,
    input  logic [i2cms_pkg::BUF_AW-1:0] rd_addr,
    output logic [7:0]                 rd_data
);

    logic [7:0] mem [i2cms_pkg::BUFFER_DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/i2cms_ctrl.sv -----
module i2cms_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [1:0]          action,
    input  logic [7:0]          byte_index,
    input  logic [7:0]          byte_value,
    input  logic                is_read,
    input  logic [6:0]          target_address,
    input  logic [7:0]          transfer_length,
    input  logic [7:0]          engine_status,
    output i2cms_pkg::cmd_t     cmd,
    output i2cms_pkg::mem_req_t req
);

    logic                        busy_reg, busy_next;
    logic                        dir_reg, dir_next;
    logic [6:0]                  addr_reg, addr_next;
    logic [7:0]                  total_reg, total_next;
    logic [7:0]                  pos_reg, pos_next;
    logic [i2cms_pkg::CNT_W-1:0] count_reg, count_next;
    logic [7:0]                  status;
    logic [i2cms_pkg::CNT_W-1:0] index_ext;

    assign status    = engine_status & i2cms_pkg::ST_MASK;
    assign index_ext = {1'b0, byte_index};

    always_comb
    begin
        busy_next  = busy_reg;
        dir_next   = dir_reg;
        addr_next  = addr_reg;
        total_next = total_reg;
        pos_next   = pos_reg;
        count_next = count_reg;
        cmd        = '0;
        req        = '0;

        unique case (action)
            i2cms_pkg::ACT_LOAD:
            begin
                if (index_ext < i2cms_pkg::DEPTH_CNT)
                begin
                    req.send_we    = 1'b1;
                    req.send_waddr = byte_index[i2cms_pkg::BUF_AW-1:0];
                    req.send_wdata = byte_value;
                end
            end
            i2cms_pkg::ACT_START:
            begin
                busy_next  = 1'b1;
                dir_next   = is_read;
                addr_next  = target_address;
                total_next = transfer_length;
                pos_next   = 8'd0;
                if (is_read)
                begin
                    count_next = '0;
                end
                cmd.set_start = 1'b1;
            end
            i2cms_pkg::ACT_EVENT:
            begin
                if (busy_reg && status != i2cms_pkg::ST_IDLE)
                begin
                    priority if (status == i2cms_pkg::ST_START ||
                                 status == i2cms_pkg::ST_RSTART)
                    begin
                        cmd.load_valid      = 1'b1;
                        cmd.load_byte       = {addr_reg, dir_reg};
                        cmd.ack_mode        = i2cms_pkg::ACK_SET;
                        cmd.clear_interrupt = 1'b1;
                        cmd.clear_start     = 1'b1;
                    end
                    else if (status == i2cms_pkg::ST_ARB_LOST)
                    begin
                        cmd.finished = 1'b1;
                        cmd.outcome  = i2cms_pkg::RES_ARB_LOST;
                        busy_next    = 1'b0;
                    end
                    else if (status == i2cms_pkg::ST_BUS_ERROR)
                    begin
                        cmd.send_stop       = 1'b1;
                        cmd.ack_mode        = i2cms_pkg::ACK_SET;
                        cmd.clear_interrupt = 1'b1;
                        cmd.finished        = 1'b1;
                        cmd.outcome         = i2cms_pkg::RES_BUS_ERROR;
                        busy_next           = 1'b0;
                    end
                    else if (!dir_reg)
                    begin
                        priority if (status == i2cms_pkg::ST_MT_SLA_ACK ||
                                     status == i2cms_pkg::ST_MT_DATA_ACK)
                        begin
                            if (pos_reg < total_reg)
                            begin
                                pos_next            = pos_reg + 8'd1;
                                cmd.load_valid      = 1'b1;
                                cmd.ack_mode        = i2cms_pkg::ACK_SET;
                                cmd.clear_interrupt = 1'b1;
                                if ({1'b0, pos_reg} < i2cms_pkg::DEPTH_CNT)
                                begin
                                    cmd.use_send   = 1'b1;
                                    req.send_re    = 1'b1;
                                    req.send_raddr = pos_reg[i2cms_pkg::BUF_AW-1:0];
                                end
                            end
                            else
                            begin
                                cmd.send_stop       = 1'b1;
                                cmd.ack_mode        = i2cms_pkg::ACK_SET;
                                cmd.clear_interrupt = 1'b1;
                                cmd.finished        = 1'b1;
                                busy_next           = 1'b0;
                            end
                        end
                        else if (status == i2cms_pkg::ST_MT_SLA_NACK ||
                                 status == i2cms_pkg::ST_MT_DATA_NACK)
                        begin
                            cmd.send_stop       = 1'b1;
                            cmd.ack_mode        = i2cms_pkg::ACK_SET;
                            cmd.clear_interrupt = 1'b1;
                            cmd.finished        = 1'b1;
                            busy_next           = 1'b0;
                        end
                        else
                        begin
                            cmd.clear_interrupt = 1'b1;
                        end
                    end
                    else
                    begin
                        priority if (status == i2cms_pkg::ST_MR_SLA_ACK)
                        begin
                            cmd.ack_mode        = i2cms_pkg::ACK_SET;
                            cmd.clear_interrupt = 1'b1;
                        end
                        else if (status == i2cms_pkg::ST_MR_SLA_NACK)
                        begin
                            cmd.send_stop       = 1'b1;
                            cmd.ack_mode        = i2cms_pkg::ACK_SET;
                            cmd.clear_interrupt = 1'b1;
                            cmd.finished        = 1'b1;
                            busy_next           = 1'b0;
                        end
                        else if (status == i2cms_pkg::ST_MR_DATA_ACK ||
                                 status == i2cms_pkg::ST_MR_DATA_NACK)
                        begin
                            // full store drops the byte and holds the count
                            if (count_reg < i2cms_pkg::DEPTH_CNT)
                            begin
                                req.recv_we    = 1'b1;
                                req.recv_waddr = count_reg[i2cms_pkg::BUF_AW-1:0];
                                req.recv_wdata = byte_value;
                                count_next     = count_reg + 9'd1;
                            end
                            cmd.clear_interrupt = 1'b1;
                            if (status == i2cms_pkg::ST_MR_DATA_ACK)
                            begin
                                cmd.ack_mode = (count_next < {1'b0, total_reg}) ?
                                               i2cms_pkg::ACK_SET : i2cms_pkg::ACK_CLEAR;
                            end
                            else
                            begin
                                cmd.send_stop = 1'b1;
                                cmd.ack_mode  = i2cms_pkg::ACK_SET;
                                cmd.finished  = 1'b1;
                                busy_next     = 1'b0;
                            end
                        end
                        else
                        begin
                            cmd.clear_interrupt = 1'b1;
                        end
                    end
                end
            end
            i2cms_pkg::ACT_READ:
            begin
                if (index_ext < count_reg && index_ext < i2cms_pkg::DEPTH_CNT)
                begin
                    cmd.use_recv   = 1'b1;
                    req.recv_re    = 1'b1;
                    req.recv_raddr = byte_index[i2cms_pkg::BUF_AW-1:0];
                end
            end
        endcase

        cmd.received_count = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            dir_reg   <= 1'b0;
            addr_reg  <= '0;
            total_reg <= '0;
            pos_reg   <= '0;
            count_reg <= '0;
        end
        else if (accept)
        begin
            busy_reg  <= busy_next;
            dir_reg   <= dir_next;
            addr_reg  <= addr_next;
            total_reg <= total_next;
            pos_reg   <= pos_next;
            count_reg <= count_next;
        end
    end

endmodule

// ----- hw/rtl/i2c_master_status_sequencer.sv -----
// a result moves through the decode stage register and then the result register
// throughput: one request per cycle; the decode stage holds one request while
// the result register is stalled, so in_ready drops only when both are full
// the store reads are registered at accept and set the two-stage depth
// reset: asynchronous active low; clears the transfer state and the valid
// flags; both byte stores keep their contents and need no clearing pass
module i2c_master_status_sequencer (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  action,
    input  logic [7:0]                  byte_index,
    input  logic [7:0]                  byte_value,
    input  logic                        is_read,
    input  logic [6:0]                  target_address,
    input  logic [7:0]                  transfer_length,
    input  logic [7:0]                  engine_status,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        set_start,
    output logic                        load_valid,
    output logic [7:0]                  load_byte,
    output logic [1:0]                  ack_mode,
    output logic                        send_stop,
    output logic                        clear_start,
    output logic                        clear_interrupt,
    output logic                        finished,
    output logic [1:0]                  outcome,
    output logic [i2cms_pkg::CNT_W-1:0] received_count,
    output logic [7:0]                  read_byte
);

    logic                 accept;
    logic                 advance;
    i2cms_pkg::cmd_t      cmd;
    i2cms_pkg::mem_req_t  req;
    logic [7:0]           send_rd;
    logic [7:0]           recv_rd;
    logic                 s1_valid_reg;
    i2cms_pkg::cmd_t      s1_cmd_reg;
    logic                 out_valid_reg;
    i2cms_pkg::result_t   res_reg, res_next;

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || advance;
    assign accept   = in_valid && in_ready;

    i2cms_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .action          (action),
        .byte_index      (byte_index),
        .byte_value      (byte_value),
        .is_read         (is_read),
        .target_address  (target_address),
        .transfer_length (transfer_length),
        .engine_status   (engine_status),
        .cmd             (cmd),
        .req             (req)
    );

    i2cms_store u_send_store (
        .clk     (clk),
        .wr_en   (accept && req.send_we),
        .wr_addr (req.send_waddr),
        .wr_data (req.send_wdata),
        .rd_en   (accept && req.send_re),
        .rd_addr (req.send_raddr),
        .rd_data (send_rd)
    );

    i2cms_store u_recv_store (
        .clk     (clk),
        .wr_en   (accept && req.recv_we),
        .wr_addr (req.recv_waddr),
        .wr_data (req.recv_wdata),
        .rd_en   (accept && req.recv_re),
        .rd_addr (req.recv_raddr),
        .rd_data (recv_rd)
    );

    always_comb
    begin
        res_next.set_start       = s1_cmd_reg.set_start;
        res_next.load_valid      = s1_cmd_reg.load_valid;
        res_next.load_byte       = s1_cmd_reg.use_send ? send_rd : s1_cmd_reg.load_byte;
        res_next.ack_mode        = s1_cmd_reg.ack_mode;
        res_next.send_stop       = s1_cmd_reg.send_stop;
        res_next.clear_start     = s1_cmd_reg.clear_start;
        res_next.clear_interrupt = s1_cmd_reg.clear_interrupt;
        res_next.finished        = s1_cmd_reg.finished;
        res_next.outcome         = s1_cmd_reg.outcome;
        res_next.received_count  = s1_cmd_reg.received_count;
        res_next.read_byte       = s1_cmd_reg.use_recv ? recv_rd : 8'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg <= cmd;
        end
        if (advance && s1_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign set_start       = res_reg.set_start;
    assign load_valid      = res_reg.load_valid;
    assign load_byte       = res_reg.load_byte;
    assign ack_mode        = res_reg.ack_mode;
    assign send_stop       = res_reg.send_stop;
    assign clear_start     = res_reg.clear_start;
    assign clear_interrupt = res_reg.clear_interrupt;
    assign finished        = res_reg.finished;
    assign outcome         = res_reg.outcome;
    assign received_count  = res_reg.received_count;
    assign read_byte       = res_reg.read_byte;

    a_load_acks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.load_valid |->
            res_reg.ack_mode == i2cms_pkg::ACK_SET && res_reg.clear_interrupt)
        else $error("byte load without acknowledge set and interrupt release");

    a_stop_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.send_stop |-> res_reg.finished)
        else $error("stop requested without ending the transfer");

    a_outcome_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.outcome != i2cms_pkg::RES_NORMAL |-> res_reg.finished)
        else $error("abnormal outcome on a result that does not finish");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_valid_reg && !out_ready |-> !in_ready)
        else $error("request accepted while both stages are full");

endmodule
